@@ hdl/ntab_pkg.sv @@
// shared types and constants for the name table
package ntab_pkg;

  // fixed field widths
  localparam int unsigned KEY_BYTES = 19;
  localparam int unsigned NAME_W    = 8 * KEY_BYTES;
  localparam int unsigned CNT_W     = 7;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_LIST   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_CREATED   = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_FOUND     = 3'd6,
    ST_LIST      = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FILL,
    FSM_RESP
  } fsm_e;

  // one stored name, byte 0 in the lowest bits of low
  typedef struct packed {
    logic [23:0] high;
    logic [63:0] mid;
    logic [63:0] low;
  } name_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] key_low;
    logic [63:0] key_mid;
    logic [23:0] key_high;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] position;
    logic [63:0]      entry_low;
    logic [63:0]      entry_mid;
    logic [23:0]      entry_high;
    logic [CNT_W-1:0] occupancy;
    logic             final_res;
  } res_t;

  // ring control from the sequencer to the cells
  typedef struct packed {
    logic shift;
    logic inject;
  } ring_ctl_t;

endpackage

@@ hdl/ntab_cell.sv @@
// one slot of the rotating name ring
module ntab_cell
  import ntab_pkg::*;
(
  input  logic      clk_i,
  input  ring_ctl_t ctl_i,
  input  name_t     neighbour_i,
  input  name_t     inject_data_i,
  output name_t     entry_o
);

  name_t entry_q;
  name_t entry_d;

  // take the neighbour's name, or a new one at the tail
  always_comb begin
    entry_d = ctl_i.inject ? inject_data_i : neighbour_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

@@ hdl/ntab_ctrl.sv @@
// sequencer: request decode, ring scan, entry count and result register
module ntab_ctrl
  import ntab_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned NAME_BYTES = 19
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  req_t      req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output res_t      res_o,
  input  name_t     head_i,
  output ring_ctl_t ring_ctl_o,
  output name_t     inject_data_o
);

  fsm_e             state_q, state_d;
  logic [CNT_W-1:0] step_q, step_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic             found_q, found_d;
  status_e          status_q, status_d;
  kind_e            kind_q;
  name_t            key_q, hold_q;
  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;
  logic             key_load, hold_load, out_load;
  logic             last_step, in_range, hit, out_free, advance;

  // zero every byte past the name limit or past the first zero byte
  function automatic name_t normalise(req_t r);
    logic [NAME_W-1:0] raw;
    logic [NAME_W-1:0] res;
    logic [7:0]        b;
    logic              ended;
    raw   = {r.key_high, r.key_mid, r.key_low};
    res   = '0;
    ended = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      b = raw[8*i +: 8];
      if (i >= NAME_BYTES || ended) begin
        b = 8'd0;
      end
      if (b == 8'd0) begin
        ended = 1'b1;
      end
      res[8*i +: 8] = b;
    end
    return name_t'(res);
  endfunction

  assign last_step = (step_q == CNT_W'(CAPACITY - 1));
  assign in_range  = (step_q < count_q);
  assign hit       = in_range && (head_i == key_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign advance   = (kind_q != KIND_LIST) || !in_range || out_free;

  // next state and ring control
  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    count_d       = count_q;
    idx_d         = idx_q;
    pos_d         = pos_q;
    found_d       = found_q;
    status_d      = status_q;
    key_load      = 1'b0;
    hold_load     = 1'b0;
    out_load      = 1'b0;
    out_d         = out_q;
    ring_ctl_o    = '0;
    inject_data_o = key_q;
    in_stall_o    = (state_q != FSM_IDLE);

    case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          key_load = 1'b1;
          step_d   = '0;
          found_d  = 1'b0;
          idx_d    = '0;
          pos_d    = '0;
          state_d  = FSM_SCAN;
          case (req_i.kind)
            KIND_CREATE: begin
              if (count_q >= CNT_W'(CAPACITY)) begin
                status_d = ST_FULL;
                state_d  = FSM_RESP;
              end
            end
            KIND_SEARCH: begin
              if (count_q == '0) begin
                status_d = ST_NOT_FOUND;
                state_d  = FSM_RESP;
              end
            end
            default: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = FSM_RESP;
              end
            end
          endcase
        end
      end

      FSM_SCAN: begin
        if (advance) begin
          ring_ctl_o.shift = 1'b1;
          step_d           = step_q + 1'b1;
          case (kind_q)
            KIND_CREATE: begin
              if (hit) begin
                found_d = 1'b1;
              end
              // append behind the last occupied slot
              if (step_q == count_q && !found_q) begin
                ring_ctl_o.inject = 1'b1;
              end
              if (last_step) begin
                status_d = found_q ? ST_DUPLICATE : ST_CREATED;
                count_d  = found_q ? count_q : count_q + 1'b1;
                state_d  = FSM_RESP;
              end
            end
            KIND_LIST: begin
              if (in_range) begin
                out_load         = 1'b1;
                out_d            = '0;
                out_d.status     = ST_LIST;
                out_d.position   = step_q + 1'b1;
                out_d.entry_low  = head_i.low;
                out_d.entry_mid  = head_i.mid;
                out_d.entry_high = head_i.high;
                out_d.occupancy  = count_q;
                out_d.final_res  = (step_q + 1'b1 == count_q);
              end
              if (last_step) begin
                state_d = FSM_IDLE;
              end
            end
            default: begin
              if (hit && !found_q) begin
                found_d = 1'b1;
                idx_d   = step_q;
              end
              // keep the last entry to refill the hole
              if (kind_q == KIND_DELETE && step_q == count_q - 1'b1) begin
                hold_load = 1'b1;
              end
              // a hit in the final slot counts on this same step
              if (last_step) begin
                if (!found_d) begin
                  status_d = ST_NOT_FOUND;
                  state_d  = FSM_RESP;
                end else if (kind_q == KIND_DELETE) begin
                  step_d  = '0;
                  state_d = FSM_FILL;
                end else begin
                  status_d = ST_FOUND;
                  pos_d    = idx_d + 1'b1;
                  state_d  = FSM_RESP;
                end
              end
            end
          endcase
        end
      end

      // second lap of a delete: move the last entry into the freed slot
      FSM_FILL: begin
        ring_ctl_o.shift  = 1'b1;
        ring_ctl_o.inject = (step_q == idx_q);
        inject_data_o     = hold_q;
        step_d            = step_q + 1'b1;
        if (last_step) begin
          count_d  = count_q - 1'b1;
          status_d = ST_DELETED;
          state_d  = FSM_RESP;
        end
      end

      FSM_RESP: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_d           = '0;
          out_d.status    = status_q;
          out_d.position  = pos_q;
          out_d.occupancy = count_q;
          out_d.final_res = 1'b1;
          state_d         = FSM_IDLE;
        end
      end

      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      found_q     <= 1'b0;
      status_q    <= ST_CREATED;
      kind_q      <= KIND_CREATE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      found_q     <= found_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
      if (key_load) begin
        kind_q <= req_i.kind;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (key_load) begin
      key_q <= normalise(req_i);
    end
    if (hold_load) begin
      hold_q <= head_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

@@ hdl/name_table_insert_delete_search.sv @@
// top level of the name table: ring of name cells and its sequencer
//
// Usage: one request transaction on the input channel (kind plus a name of
// up to 19 bytes) gives one result transaction, or for a list one per
// stored entry, the last one flagged by final_res. Both channels move a
// transaction when valid is high and stall is low.
// The names live in a ring of CAPACITY cells that rotates one slot per
// cycle while a lap runs, unless a list waits on a stalled output. Every
// request that touches the table drives one full lap, and a delete hit a
// second lap that refills the freed slot, so the ring is back in slot
// order at the end. A create on a full table, or any other request on an
// empty one, is answered with no lap.
// One request is in work at a time; in_stall_o is high from acceptance
// until the lap is over and the last result has entered the output register.
// A stalled output holds its result; during a list the ring waits for it.
// Reset empties the table at once (entry count to zero); no clearing pass.
module name_table_insert_delete_search
  import ntab_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned NAME_BYTES = 19
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t res_o
);

  ring_ctl_t ring_ctl;
  name_t     inject_data;
  name_t     cell_entry [CAPACITY];

  // sequencer
  ntab_ctrl #(
    .CAPACITY   (CAPACITY),
    .NAME_BYTES (NAME_BYTES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_i         (req_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .res_o         (res_o),
    .head_i        (cell_entry[0]),
    .ring_ctl_o    (ring_ctl),
    .inject_data_o (inject_data)
  );

  // ring of cells, each taking its upper neighbour; the tail takes the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ring_ctl_t cell_ctl;

    assign cell_ctl.shift  = ring_ctl.shift;
    assign cell_ctl.inject = (i == CAPACITY - 1) ? ring_ctl.inject : 1'b0;

    ntab_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (cell_ctl),
      .neighbour_i   (cell_entry[(i + 1) % CAPACITY]),
      .inject_data_i (inject_data),
      .entry_o       (cell_entry[i])
    );
  end

endmodule

@@ hdl/ntab_checker.sv @@
// port-level checks for the name table, bound to the top level
module ntab_checker
  import ntab_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input res_t res_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an accepted request keeps the input closed in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input reopened right after a transaction");

  // listed entries lie within the occupied slots
  a_list_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && res_o.status == ST_LIST |->
      res_o.position != '0 && res_o.position <= res_o.occupancy)
    else $error("list position outside occupied slots");

  // single results are always final and the count stays in range
  a_single_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && res_o.status != ST_LIST |->
      res_o.final_res && res_o.occupancy <= CNT_W'(CAPACITY))
    else $error("single result not final or count out of range");

endmodule

bind name_table_insert_delete_search ntab_checker #(
  .CAPACITY (CAPACITY)
) u_ntab_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .res_o       (res_o)
);

@@ test/tb_top.sv @@
// testbench for the name table: directed and random requests checked against a local table model
module tb_top;
  import ntab_pkg::*;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned NAME_BYTES = 19;
  // longest request with no output stall: delete hit takes two laps
  localparam int unsigned LAP_CYCLES = 2 * CAPACITY + 2;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t req_i       = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  res_t res_o;

  name_table_insert_delete_search #(
    .CAPACITY   (CAPACITY),
    .NAME_BYTES (NAME_BYTES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_i       (req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_o)
  );

  // local copy of the directory and the results it predicts
  name_t       dir_slot [CAPACITY];
  int unsigned dir_used;
  res_t        pending_res [$];
  name_t       name_pool [$];

  int unsigned errors;
  int unsigned results_seen;
  int unsigned kind_cnt [4];
  int unsigned peak_used;
  bit          idle_on;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // keep only the bytes up to the first zero byte and within the name limit
  function automatic name_t canon_name(input name_t n);
    name_t      c;
    logic [7:0] b;
    bit         ended;
    c     = '0;
    ended = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      b = n[8*i +: 8];
      if (i >= NAME_BYTES || ended) b = 8'h00;
      if (b == 8'h00) ended = 1'b1;
      c[8*i +: 8] = b;
    end
    return c;
  endfunction

  function automatic int dir_find(input name_t key);
    for (int i = 0; i < dir_used; i++)
      if (dir_slot[i] == key) return i;
    return -1;
  endfunction

  // apply one request to the local directory and queue its results
  function automatic void dir_apply(input req_t r);
    name_t key;
    res_t  res;
    int    idx;
    key = canon_name({r.key_high, r.key_mid, r.key_low});
    res = '0;
    res.final_res = 1'b1;
    kind_cnt[r.kind]++;
    case (r.kind)
      KIND_CREATE: begin
        if (dir_used >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (dir_find(key) >= 0) begin
          res.status = ST_DUPLICATE;
        end else begin
          dir_slot[dir_used] = key;
          dir_used++;
          res.status = ST_CREATED;
        end
      end
      KIND_DELETE: begin
        idx = dir_find(key);
        if (dir_used == 0) begin
          res.status = ST_EMPTY;
        end else if (idx < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          // last entry fills the hole
          dir_slot[idx] = dir_slot[dir_used-1];
          dir_used--;
          res.status = ST_DELETED;
        end
      end
      KIND_SEARCH: begin
        idx = dir_find(key);
        if (idx < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.status   = ST_FOUND;
          res.position = CNT_W'(idx + 1);
        end
      end
      default: begin
        if (dir_used == 0) res.status = ST_EMPTY;
      end
    endcase
    res.occupancy = CNT_W'(dir_used);
    if (r.kind == KIND_LIST && dir_used != 0) begin
      for (int i = 0; i < dir_used; i++) begin
        res.status     = ST_LIST;
        res.position   = CNT_W'(i + 1);
        res.entry_low  = dir_slot[i].low;
        res.entry_mid  = dir_slot[i].mid;
        res.entry_high = dir_slot[i].high;
        res.final_res  = (i + 1 == dir_used);
        pending_res.push_back(res);
      end
    end else begin
      pending_res.push_back(res);
    end
    if (dir_used > peak_used) peak_used = dir_used;
  endfunction

  // name of len nonzero bytes, zero padded
  function automatic name_t make_name(input int len);
    name_t n;
    n = '0;
    for (int i = 0; i < len; i++) n[8*i +: 8] = 8'($urandom_range(1, 255));
    return n;
  endfunction

  // random rubbish after the terminating zero byte, same name once normalised
  function automatic name_t dress(input name_t n);
    name_t d;
    bit    past;
    d    = n;
    past = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (past) d[8*i +: 8] = 8'($urandom);
      if (n[8*i +: 8] == 8'h00) past = 1'b1;
    end
    return d;
  endfunction

  function automatic name_t rand_bits();
    name_t n;
    n.low  = {$urandom, $urandom};
    n.mid  = {$urandom, $urandom};
    n.high = 24'($urandom);
    return n;
  endfunction

  // one request transaction, entered into the model when accepted
  task automatic send_req(input kind_e k, input name_t n);
    req_t r;
    r.kind     = k;
    r.key_low  = n.low;
    r.key_mid  = n.mid;
    r.key_high = n.high;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_i      <= r;
    do @(posedge clk_i); while (in_stall_o);
    dir_apply(r);
    @(negedge clk_i);
  endtask

  // output stall in random bursts
  always begin
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic cmp_field(input string what, input logic [63:0] got,
                           input logic [63:0] want);
    if (got !== want) report(what, got, want);
  endtask

  // compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : check_res
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_res.size() == 0) begin
        report("unexpected result status", res_o.status, '0);
      end else begin
        want = pending_res.pop_front();
        cmp_field("status",     res_o.status,     want.status);
        cmp_field("position",   res_o.position,   want.position);
        cmp_field("entry_low",  res_o.entry_low,  want.entry_low);
        cmp_field("entry_mid",  res_o.entry_mid,  want.entry_mid);
        cmp_field("entry_high", res_o.entry_high, want.entry_high);
        cmp_field("occupancy",  res_o.occupancy,  want.occupancy);
        cmp_field("final_res",  res_o.final_res,  want.final_res);
      end
    end
  end

  // empty table, normalisation, duplicates, swap-with-last delete
  task automatic test_directed();
    name_t nul, ab, ones, zz;
    nul  = '0;
    ab   = '0;
    ab[15:0] = 16'h6261;
    ones = '1;
    zz   = make_name(19);
    send_req(KIND_LIST,   nul);
    send_req(KIND_DELETE, nul);
    send_req(KIND_SEARCH, ones);
    send_req(KIND_CREATE, nul);
    send_req(KIND_CREATE, dress(nul));
    send_req(KIND_CREATE, dress(ab));
    send_req(KIND_SEARCH, ab);
    send_req(KIND_CREATE, ones);
    send_req(KIND_SEARCH, ones);
    send_req(KIND_CREATE, dress(ab));
    send_req(KIND_LIST,   rand_bits());
    send_req(KIND_DELETE, zz);
    send_req(KIND_SEARCH, zz);
    send_req(KIND_DELETE, dress(nul));
    send_req(KIND_SEARCH, ones);
    send_req(KIND_DELETE, ab);
    send_req(KIND_LIST,   nul);
    send_req(KIND_DELETE, ones);
    send_req(KIND_SEARCH, ones);
    send_req(KIND_LIST,   nul);
    send_req(KIND_DELETE, ones);
  endtask

  // fill to capacity, full before duplicate, full list, drain to empty
  task automatic test_fill();
    name_t n;
    for (int i = 0; i < CAPACITY; i++) begin
      n = make_name($urandom_range(1, 19));
      n[7:0] = 8'(i + 1);
      send_req(KIND_CREATE, ($urandom_range(0, 1) != 0) ? dress(n) : n);
    end
    send_req(KIND_CREATE, make_name(5) | 152'hC8);
    send_req(KIND_CREATE, dir_slot[3]);
    send_req(KIND_SEARCH, dir_slot[CAPACITY-1]);
    send_req(KIND_SEARCH, dir_slot[0]);
    send_req(KIND_DELETE, make_name(19) | 152'hC9);
    send_req(KIND_LIST,   '0);
    while (dir_used != 0) begin
      n = dir_slot[$urandom_range(0, dir_used - 1)];
      send_req(KIND_DELETE, dress(n));
      if ($urandom_range(0, 7) == 0) send_req(KIND_SEARCH, n);
    end
    send_req(KIND_DELETE, '0);
    send_req(KIND_LIST,   '0);
  endtask

  // one random request: mostly known names, some raw noise
  task automatic random_req();
    int    pick;
    kind_e k;
    name_t n;
    pick = $urandom_range(0, 99);
    if (pick < 38)      k = KIND_CREATE;
    else if (pick < 62) k = KIND_DELETE;
    else if (pick < 93) k = KIND_SEARCH;
    else                k = KIND_LIST;
    pick = $urandom_range(0, 99);
    if (pick < 12)
      n = rand_bits();
    else if (pick < 40 && dir_used != 0)
      n = dir_slot[$urandom_range(0, dir_used - 1)];
    else
      n = name_pool[$urandom_range(0, name_pool.size() - 1)];
    if ($urandom_range(0, 1) != 0) n = dress(n);
    send_req(k, n);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < 48; i++) name_pool.push_back(make_name($urandom_range(0, 19)));
    for (int i = 0; i < count; i++) begin
      // stretches without idling now and then
      if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      random_req();
    end
  endtask

  // closing stretch at full rate
  task automatic test_full_rate(input int count);
    idle_on = 1'b0;
    for (int i = 0; i < count; i++) random_req();
    send_req(KIND_LIST, '0);
  endtask

  // main sequence
  initial begin
    idle_on = 1'b1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_fill();
    test_random(200);
    test_full_rate(40);
    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (LAP_CYCLES) @(posedge clk_i);
    $display("covered %0d creates, %0d deletes, %0d searches, %0d lists",
             kind_cnt[KIND_CREATE], kind_cnt[KIND_DELETE],
             kind_cnt[KIND_SEARCH], kind_cnt[KIND_LIST]);
    $display("%0d results checked, table reached %0d of %0d entries, %0d mismatches",
             results_seen, peak_used, CAPACITY, errors);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("timeout, %0d results still outstanding", pending_res.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
